/* design/sparse_set_index_table_core_macros.svh */
// Assertion macros used by the sparse set table sequencer (ssit_ctrl).
`ifndef SPARSE_SET_INDEX_TABLE_CORE_MACROS_SVH
`define SPARSE_SET_INDEX_TABLE_CORE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define SSIT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SSIT_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SSIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ssit_pkg.sv */
// Shared types and constants of the sparse set table.
package ssit_pkg;

  localparam int KIND_W   = 2;
  localparam int ENTITY_W = 10;
  localparam int SLOT_W   = 8;
  localparam int COUNT_W  = 9;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAP,
    ST_OWN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic                moved;
    logic [ENTITY_W-1:0] moved_entity;
    logic                refused;
    logic [COUNT_W-1:0]  entry_count;
  } res_t;

endpackage

/* design/ssit_if.sv */
// Request and result channel interfaces of the sparse set table.
interface ssit_req_if import ssit_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [ENTITY_W-1:0] entity;

  modport source (output valid, kind, entity, input ready);
  modport sink   (input valid, kind, entity, output ready);
endinterface

interface ssit_rsp_if import ssit_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [SLOT_W-1:0]   slot;
  logic                moved;
  logic [ENTITY_W-1:0] moved_entity;
  logic                refused;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, found, slot, moved, moved_entity, refused, entry_count,
                  input ready);
  modport sink   (input valid, found, slot, moved, moved_entity, refused, entry_count,
                  output ready);
endinterface

/* design/ssit_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module ssit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/ssit_ctrl.sv */
// Sequencer: clearing pass, read-modify-write of the sparse map and dense owner RAMs.
`include "sparse_set_index_table_core_macros.svh"
module ssit_ctrl import ssit_pkg::*; #(
  parameter int ENTITY_COUNT = 1024,
  parameter int CAPACITY     = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ssit_req_if.sink                          req,
  output logic                              res_valid,
  input  logic                              res_ready,
  output res_t                              res,
  output logic                              sp_we,
  output logic [$clog2(ENTITY_COUNT)-1:0]   sp_waddr,
  output logic [$clog2(CAPACITY):0]         sp_wdata,
  output logic                              sp_re,
  output logic [$clog2(ENTITY_COUNT)-1:0]   sp_raddr,
  input  logic [$clog2(CAPACITY):0]         sp_rdata,
  output logic                              dn_we,
  output logic [$clog2(CAPACITY)-1:0]       dn_waddr,
  output logic [$clog2(ENTITY_COUNT)-1:0]   dn_wdata,
  output logic                              dn_re,
  output logic [$clog2(CAPACITY)-1:0]       dn_raddr,
  input  logic [$clog2(ENTITY_COUNT)-1:0]   dn_rdata
);

  localparam int EW = $clog2(ENTITY_COUNT);
  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [EW-1:0] CLR_LAST = EW'(ENTITY_COUNT - 1);
  localparam logic [CW-1:0] CAP_FULL = CW'(CAPACITY);

  state_t        state_r, state_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  logic          range_r, range_nxt;
  logic [EW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] last_r, last_nxt;
  res_t          res_r, res_nxt;

  logic          in_fire;
  logic          map_present;
  logic [SW-1:0] map_slot;
  logic [SW-1:0] used_last;
  logic          count_quiet;
  logic          swap_step;

  assign req.ready   = (state_r == ST_IDLE);
  assign in_fire     = req.valid && req.ready;
  assign map_present = range_r && sp_rdata[SW];
  assign map_slot    = map_present ? sp_rdata[SW-1:0] : '0;
  assign used_last   = SW'(used_r - CW'(1));
  assign res_valid   = (state_r == ST_EMIT);
  assign res         = res_r;
  assign count_quiet = (state_r == ST_IDLE) || (state_r == ST_EMIT) || (state_r == ST_CLEAR);
  assign swap_step   = (state_r == ST_OWN) && (slot_r != last_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE:  if (req.valid) state_nxt = ST_MAP;
      ST_MAP: begin
        if (kind_r == KIND_REMOVE && map_present) state_nxt = ST_OWN;
        else state_nxt = ST_EMIT;
      end
      ST_OWN:   state_nxt = ST_EMIT;
      ST_EMIT:  if (res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    sp_we        = 1'b0;
    sp_waddr     = ent_r;
    sp_wdata     = '0;
    sp_re        = 1'b0;
    sp_raddr     = EW'(req.entity);
    dn_we        = 1'b0;
    dn_waddr     = SW'(used_r);
    dn_wdata     = ent_r;
    dn_re        = 1'b0;
    dn_raddr     = used_last;
    kind_nxt     = kind_r;
    ent_nxt      = ent_r;
    range_nxt    = range_r;
    clr_addr_nxt = clr_addr_r;
    used_nxt     = used_r;
    slot_nxt     = slot_r;
    last_nxt     = last_r;
    res_nxt      = res_r;
    unique case (state_r)
      ST_CLEAR: begin
        sp_we        = 1'b1;
        sp_waddr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + EW'(1);
      end
      ST_IDLE: begin
        if (req.valid) begin
          sp_re     = 1'b1;
          kind_nxt  = req.kind;
          ent_nxt   = EW'(req.entity);
          range_nxt = (32'(req.entity) < 32'(ENTITY_COUNT));
        end
      end
      ST_MAP: begin
        res_nxt = '0;
        unique case (kind_r)
          KIND_INSERT: begin
            if (map_present) begin
              res_nxt.found = 1'b1;
              res_nxt.slot  = SLOT_W'(map_slot);
            end else if (!range_r || used_r == CAP_FULL) begin
              res_nxt.refused = 1'b1;
            end else begin
              // append at the end of the dense list
              sp_we        = 1'b1;
              sp_wdata     = {1'b1, SW'(used_r)};
              dn_we        = 1'b1;
              used_nxt     = used_r + CW'(1);
              res_nxt.slot = SLOT_W'(used_r);
            end
          end
          KIND_REMOVE: begin
            if (map_present) begin
              // drop the entry now, fetch the owner of the last slot
              sp_we    = 1'b1;
              dn_re    = 1'b1;
              slot_nxt = map_slot;
              last_nxt = used_last;
            end
          end
          default: begin
            res_nxt.found = map_present;
            res_nxt.slot  = SLOT_W'(map_slot);
          end
        endcase
        res_nxt.entry_count = COUNT_W'(used_nxt);
      end
      ST_OWN: begin
        res_nxt       = '0;
        res_nxt.found = 1'b1;
        res_nxt.slot  = SLOT_W'(slot_r);
        if (slot_r != last_r) begin
          // move the last entry into the freed slot
          dn_we                = 1'b1;
          dn_waddr             = slot_r;
          dn_wdata             = dn_rdata;
          sp_we                = 1'b1;
          sp_waddr             = dn_rdata;
          sp_wdata             = {1'b1, slot_r};
          res_nxt.moved        = 1'b1;
          res_nxt.moved_entity = ENTITY_W'(dn_rdata);
        end
        used_nxt            = used_r - CW'(1);
        res_nxt.entry_count = COUNT_W'(used_nxt);
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      used_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      used_r     <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    ent_r   <= ent_nxt;
    range_r <= range_nxt;
    slot_r  <= slot_nxt;
    last_r  <= last_nxt;
    res_r   <= res_nxt;
  end

  `SSIT_ASSERT_ALWAYS(a_used_bound, used_r <= CAP_FULL, "entry count above capacity")
  `SSIT_ASSERT_NEXT(a_accept_to_map, in_fire, state_r == ST_MAP, "accepted item skipped map read")
  `SSIT_ASSERT_NEXT(a_count_hold, count_quiet, $stable(used_r), "entry count changed idle")
  `SSIT_ASSERT_IMPLY(a_moved_distinct, swap_step, dn_rdata != ent_r, "moved entity is removed one")

endmodule

/* design/ssit_out_stage.sv */
// Output register between the sequencer and the result channel.
module ssit_out_stage import ssit_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  output logic       res_ready,
  input  res_t       res,
  ssit_rsp_if.source rsp
);

  logic out_valid_r, out_valid_nxt;
  res_t out_res_r;
  logic load;

  assign res_ready = !out_valid_r || rsp.ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (load) begin
      out_valid_nxt = 1'b1;
    end else if (rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= res;
    end
  end

  assign rsp.valid        = out_valid_r;
  assign rsp.found        = out_res_r.found;
  assign rsp.slot         = out_res_r.slot;
  assign rsp.moved        = out_res_r.moved;
  assign rsp.moved_entity = out_res_r.moved_entity;
  assign rsp.refused      = out_res_r.refused;
  assign rsp.entry_count  = out_res_r.entry_count;

endmodule

/* design/sparse_set_index_table_core.sv */
// Sparse set table: entity number to dense slot, with swap-remove.
//
// Request channel in_req (valid/ready): kind (lookup, insert, remove; the spare
// code acts as a lookup) and entity. Result channel out_rsp (valid/ready):
// found, slot, moved, moved_entity, refused and entry_count, one result per item.
// The sparse map and the dense owner list live in two RAMs with registered read.
// An item is accepted only once the last has left its emit step; a lookup or
// insert first does the sparse map read, a remove also the dense owner read.
// The result goes from the map step (remove: then the owner step) through the
// emit step into the output register. A synchronous reset starts a clearing
// pass over all ENTITY_COUNT sparse map entries, one entry a cycle;
// in_req.ready stays low until it is done. The dense list is never cleared:
// only slots below the entry count are read. If the receiver stalls, the
// output register holds the finished item while the next item may still be
// accepted; that item then waits in its final step until the register is free.
module sparse_set_index_table_core import ssit_pkg::*; #(
  parameter int ENTITY_COUNT = 1024,
  parameter int CAPACITY     = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  ssit_req_if.sink   in_req,
  ssit_rsp_if.source out_rsp
);

  localparam int EW = $clog2(ENTITY_COUNT);
  localparam int SW = $clog2(CAPACITY);

  logic          sp_we, sp_re;
  logic [EW-1:0] sp_waddr, sp_raddr;
  logic [SW:0]   sp_wdata, sp_rdata;
  logic          dn_we, dn_re;
  logic [SW-1:0] dn_waddr, dn_raddr;
  logic [EW-1:0] dn_wdata, dn_rdata;
  logic          res_valid, res_ready;
  res_t          res;

  ssit_ram #(.WIDTH(SW + 1), .DEPTH(ENTITY_COUNT)) u_sparse_ram (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .re    (sp_re),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  ssit_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_dense_ram (
    .clk   (clk),
    .we    (dn_we),
    .waddr (dn_waddr),
    .wdata (dn_wdata),
    .re    (dn_re),
    .raddr (dn_raddr),
    .rdata (dn_rdata)
  );

  ssit_ctrl #(.ENTITY_COUNT(ENTITY_COUNT), .CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .sp_we     (sp_we),
    .sp_waddr  (sp_waddr),
    .sp_wdata  (sp_wdata),
    .sp_re     (sp_re),
    .sp_raddr  (sp_raddr),
    .sp_rdata  (sp_rdata),
    .dn_we     (dn_we),
    .dn_waddr  (dn_waddr),
    .dn_wdata  (dn_wdata),
    .dn_re     (dn_re),
    .dn_raddr  (dn_raddr),
    .dn_rdata  (dn_rdata)
  );

  ssit_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rsp       (out_rsp)
  );

endmodule
